[src/ppd_pkg.sv]
// ---------------------------------------------------------------------------
// ppd_pkg
// Shared types, register indexes, fixed-point constants and helper functions
// of the paraboloid patch dicer.
// ---------------------------------------------------------------------------
`default_nettype none
package ppd_pkg;

   localparam int MAX_GRID     = 8;
   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_ENTRIES = 24;
   localparam int CORDIC_RUN   = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;

   localparam int MUL_W = 34;
   localparam int ANG_W = 36;

   localparam logic [2:0] REG_RADIUS_MAX  = 3'd0;
   localparam logic [2:0] REG_HEIGHT_MIN  = 3'd1;
   localparam logic [2:0] REG_HEIGHT_MAX  = 3'd2;
   localparam logic [2:0] REG_SWEEP_ANGLE = 3'd3;
   localparam logic [2:0] REG_GRID_WIDTH  = 3'd4;
   localparam logic [2:0] REG_GRID_HEIGHT = 3'd5;

   localparam logic signed [ANG_W-1:0] Q30_PI      = 36'sd3373259426;
   localparam logic signed [ANG_W-1:0] Q30_HALF_PI = 36'sd1686629713;
   localparam logic signed [ANG_W-1:0] Q30_TWO_PI  = 36'sd6746518852;
   localparam logic signed [MUL_W-1:0] CORDIC_GAIN = 34'sd652032874;

   typedef struct packed {
      logic [15:0] u_start;
      logic [15:0] u_end;
      logic [15:0] v_start;
      logic [15:0] v_end;
   } req_item_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [15:0]        coord_s;
      logic [15:0]        coord_t;
      logic               last_vertex;
   } rsp_item_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DIV_U, ST_DIV_V, ST_THETA, ST_ZMUL, ST_ZSUM, ST_DIV_R, ST_SQRT,
      ST_RMUL, ST_RSAT, ST_CPREP, ST_CORDIC, ST_XMUL, ST_YMUL, ST_EMIT
   } state_type;

   function automatic logic signed [ANG_W-1:0] atan_q30(input logic [4:0] idx);
      logic signed [ANG_W-1:0] val;
      unique case (idx)
         5'd0:  val = 36'sd843314857;
         5'd1:  val = 36'sd497837830;
         5'd2:  val = 36'sd263043837;
         5'd3:  val = 36'sd133525159;
         5'd4:  val = 36'sd67021687;
         5'd5:  val = 36'sd33543516;
         5'd6:  val = 36'sd16775851;
         5'd7:  val = 36'sd8388437;
         5'd8:  val = 36'sd4194283;
         5'd9:  val = 36'sd2097149;
         5'd10: val = 36'sd1048576;
         5'd11: val = 36'sd524288;
         5'd12: val = 36'sd262144;
         5'd13: val = 36'sd131072;
         5'd14: val = 36'sd65536;
         5'd15: val = 36'sd32768;
         5'd16: val = 36'sd16384;
         5'd17: val = 36'sd8192;
         5'd18: val = 36'sd4096;
         5'd19: val = 36'sd2048;
         5'd20: val = 36'sd1024;
         5'd21: val = 36'sd512;
         5'd22: val = 36'sd256;
         5'd23: val = 36'sd128;
         default: val = '0;
      endcase
      return val;
   endfunction

   function automatic logic [3:0] clamp_grid(input logic [3:0] n);
      logic [3:0] res;
      if (n < 4'd2)
         res = 4'd2;
      else if (n > 4'(MAX_GRID))
         res = 4'(MAX_GRID);
      else
         res = n;
      return res;
   endfunction

endpackage
`default_nettype wire

[src/paraboloid_patch_dicer_core.sv]
// ---------------------------------------------------------------------------
// paraboloid_patch_dicer_core
// Dices one u/v patch into a grid of paraboloid vertices on a shared
// multiplier, divider, square root and CORDIC datapath.
// ---------------------------------------------------------------------------
// Usage: write the six registers through csr_we/csr_index/csr_wdata while the
// core is idle. Pulse start with a patch word on req_item while busy is low;
// busy rises the next cycle and stays high until the last vertex has been
// produced. Each vertex word appears on rsp_item for exactly one cycle with
// rsp_valid high, in row-major order; last_vertex marks the final one. The
// receiver cannot stall the core, so every word must be taken when shown.
// Sequence: the accepting edge is followed by the u and v step divisions, then
// each vertex runs on one serial datapath: the theta multiply, the height
// multiply and the height sum, a division and a square root, the radius
// multiply and saturation, one setup step plus CORDIC_STEPS rotation steps,
// the x and y multiplies and the emit step. When z is not positive the
// division, square root and radius steps are skipped and the radius is zero.
// Reset is synchronous and returns the registers to their defaults and the
// sequencer to idle.
// ---------------------------------------------------------------------------
`default_nettype none
module paraboloid_patch_dicer_core import ppd_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire req_item_type req_item,
   output logic              rsp_valid,
   output rsp_item_type      rsp_item,
   input  wire logic         csr_we,
   input  wire logic [2:0]   csr_index,
   input  wire logic [31:0]  csr_wdata
);

   // Configuration registers.
   logic [30:0]        radius_max_ff;
   logic signed [31:0] height_min_ff;
   logic [30:0]        height_max_ff;
   logic [15:0]        sweep_angle_ff;
   logic [3:0]         grid_width_ff;
   logic [3:0]         grid_height_ff;

   state_type state_ff, state_in;

   logic [15:0] us_ff, ue_ff, vs_ff, ve_ff, su_ff, sv_ff, u_ff, v_ff;
   logic [3:0]  w_ff, h_ff;
   logic [2:0]  col_ff, row_ff;
   logic [5:0]  cnt_ff;

   logic [63:0]              dq_ff;
   logic [33:0]              rem_ff;
   logic [31:0]              dvs_ff;
   logic [31:0]              sq_ff;
   logic [15:0]              theta_ff;
   logic signed [33:0]       z_ff;
   logic [30:0]              r_ff;
   logic signed [MUL_W-1:0]  x_ff, y_ff;
   logic signed [ANG_W-1:0]  a_ff;
   logic                     flip_ff;
   logic signed [31:0]       px_ff;
   logic signed [2*MUL_W-1:0] prod_ff;

   logic          rsp_valid_ff;
   rsp_item_type  rsp_item_ff;

   // Shared multiplier operands.
   logic signed [MUL_W-1:0] mul_a, mul_b;

   logic [31:0] zmax;
   logic signed [33:0] diff;
   logic [15:0] ue_cl, ve_cl;
   logic        last_vtx;
   logic [16:0] u_next, v_next;
   logic [32:0] div_sh;
   logic        div_ge;
   logic [63:0] q_next;
   logic [33:0] sq_sh, sq_trial;
   logic signed [MUL_W-1:0] x_shift, y_shift;
   logic signed [ANG_W-1:0] a_red0, a_red1;
   logic                    flip_red;
   logic signed [37:0] prod_q30;
   logic signed [33:0] z_calc;
   logic signed [31:0] prod_sat;
   logic signed [MUL_W-1:0] cos_v, sin_v;

   always_comb begin
      zmax = (height_max_ff == '0) ? 32'd1 : {1'b0, height_max_ff};
      diff = 34'(signed'({2'b00, zmax})) - 34'(height_min_ff);
      ue_cl = (req_item.u_end < req_item.u_start) ? req_item.u_start : req_item.u_end;
      ve_cl = (req_item.v_end < req_item.v_start) ? req_item.v_start : req_item.v_end;
      last_vtx = ({1'b0, col_ff} == w_ff - 4'd1) && ({1'b0, row_ff} == h_ff - 4'd1);
      u_next = {1'b0, u_ff} + {1'b0, su_ff};
      v_next = {1'b0, v_ff} + {1'b0, sv_ff};
      div_sh = {rem_ff[31:0], dq_ff[63]};
      div_ge = (div_sh >= {1'b0, dvs_ff});
      q_next = {dq_ff[62:0], div_ge};
      sq_sh = {rem_ff[31:0], dq_ff[63:62]};
      sq_trial = {sq_ff, 2'b01};
      x_shift = x_ff >>> cnt_ff[4:0];
      y_shift = y_ff >>> cnt_ff[4:0];
      z_calc = 34'(height_min_ff) + 34'(prod_ff >>> 16);
      cos_v = flip_ff ? -x_ff : x_ff;
      sin_v = flip_ff ? -y_ff : y_ff;
      prod_q30 = 38'(prod_ff >>> 30);
      if (prod_q30 > 38'sd2147483647)
         prod_sat = 32'sh7FFFFFFF;
      else if (prod_q30 < -38'sd2147483648)
         prod_sat = 32'sh80000000;
      else
         prod_sat = prod_q30[31:0];
      // Angle reduction to the right half plane.
      a_red0 = {3'b000, theta_ff, 17'd0};
      if (a_red0 > Q30_PI)
         a_red0 = a_red0 - Q30_TWO_PI;
      flip_red = 1'b0;
      a_red1 = a_red0;
      if (a_red0 > Q30_HALF_PI) begin
         a_red1 = a_red0 - Q30_PI;
         flip_red = 1'b1;
      end else if (a_red0 < -Q30_HALF_PI) begin
         a_red1 = a_red0 + Q30_PI;
         flip_red = 1'b1;
      end
   end

   always_comb begin
      unique case (state_ff)
         ST_THETA: begin
            mul_a = MUL_W'(u_ff);
            mul_b = MUL_W'(sweep_angle_ff);
         end
         ST_ZMUL: begin
            mul_a = diff;
            mul_b = MUL_W'(v_ff);
         end
         ST_RMUL: begin
            mul_a = MUL_W'(radius_max_ff);
            mul_b = MUL_W'(sq_ff);
         end
         ST_XMUL: begin
            mul_a = MUL_W'(r_ff);
            mul_b = cos_v;
         end
         ST_YMUL: begin
            mul_a = MUL_W'(r_ff);
            mul_b = sin_v;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (start) state_in = ST_DIV_U;
         ST_DIV_U:  if (cnt_ff == 6'd63) state_in = ST_DIV_V;
         ST_DIV_V:  if (cnt_ff == 6'd63) state_in = ST_THETA;
         ST_THETA:  state_in = ST_ZMUL;
         ST_ZMUL:   state_in = ST_ZSUM;
         ST_ZSUM:   state_in = (z_calc > 34'sd0) ? ST_DIV_R : ST_CPREP;
         ST_DIV_R:  if (cnt_ff == 6'd63) state_in = ST_SQRT;
         ST_SQRT:   if (cnt_ff == 6'd31) state_in = ST_RMUL;
         ST_RMUL:   state_in = ST_RSAT;
         ST_RSAT:   state_in = ST_CPREP;
         ST_CPREP:  state_in = ST_CORDIC;
         ST_CORDIC: if (cnt_ff == 6'(CORDIC_RUN - 1)) state_in = ST_XMUL;
         ST_XMUL:   state_in = ST_YMUL;
         ST_YMUL:   state_in = ST_EMIT;
         ST_EMIT:   state_in = last_vtx ? ST_IDLE : ST_THETA;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         radius_max_ff <= 31'd65536;
         height_min_ff <= '0;
         height_max_ff <= 31'd65536;
         sweep_angle_ff <= 16'd51472;
         grid_width_ff <= 4'd8;
         grid_height_ff <= 4'd8;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= (state_ff == ST_EMIT);
         if (csr_we) begin
            unique case (csr_index)
               REG_RADIUS_MAX:  radius_max_ff <= csr_wdata[30:0];
               REG_HEIGHT_MIN:  height_min_ff <= csr_wdata;
               REG_HEIGHT_MAX:  height_max_ff <= csr_wdata[30:0];
               REG_SWEEP_ANGLE: sweep_angle_ff <= csr_wdata[15:0];
               REG_GRID_WIDTH:  grid_width_ff <= csr_wdata[3:0];
               REG_GRID_HEIGHT: grid_height_ff <= csr_wdata[3:0];
               default: ;
            endcase
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            us_ff <= req_item.u_start;
            ue_ff <= ue_cl;
            vs_ff <= req_item.v_start;
            ve_ff <= ve_cl;
            u_ff <= req_item.u_start;
            v_ff <= req_item.v_start;
            col_ff <= '0;
            row_ff <= '0;
            w_ff <= clamp_grid(grid_width_ff);
            h_ff <= clamp_grid(grid_height_ff);
            dq_ff <= {48'd0, ue_cl - req_item.u_start};
            dvs_ff <= {28'd0, clamp_grid(grid_width_ff) - 4'd1};
            rem_ff <= '0;
            cnt_ff <= '0;
         end
         ST_DIV_U, ST_DIV_V, ST_DIV_R: begin
            if (cnt_ff == 6'd63) begin
               rem_ff <= '0;
               cnt_ff <= '0;
               sq_ff <= '0;
            end else begin
               rem_ff <= div_ge ? {1'b0, div_sh - {1'b0, dvs_ff}} : {1'b0, div_sh};
               cnt_ff <= cnt_ff + 6'd1;
            end
            // The u step is done: load the v range for the second division.
            if (state_ff == ST_DIV_U && cnt_ff == 6'd63) begin
               su_ff <= q_next[15:0];
               dq_ff <= {48'd0, ve_ff - vs_ff};
               dvs_ff <= {28'd0, h_ff - 4'd1};
            end else begin
               dq_ff <= q_next;
               if (state_ff == ST_DIV_V && cnt_ff == 6'd63)
                  sv_ff <= q_next[15:0];
            end
         end
         ST_THETA: ;
         ST_ZMUL: theta_ff <= prod_ff[31:16];
         ST_ZSUM: begin
            z_ff <= z_calc;
            r_ff <= '0;
            dq_ff <= {z_calc[31:0], 32'd0};
            dvs_ff <= zmax;
            rem_ff <= '0;
            cnt_ff <= '0;
         end
         ST_SQRT: begin
            if (sq_sh >= sq_trial) begin
               rem_ff <= sq_sh - sq_trial;
               sq_ff <= {sq_ff[30:0], 1'b1};
            end else begin
               rem_ff <= sq_sh;
               sq_ff <= {sq_ff[30:0], 1'b0};
            end
            dq_ff <= {dq_ff[61:0], 2'b00};
            cnt_ff <= (cnt_ff == 6'd31) ? 6'd0 : cnt_ff + 6'd1;
         end
         ST_RMUL: ;
         ST_RSAT: begin
            // The product is non-negative; clamp the Q16.16 radius to 31 bits.
            if (prod_ff[2*MUL_W-1:47] != '0)
               r_ff <= 31'h7FFFFFFF;
            else
               r_ff <= prod_ff[46:16];
         end
         ST_CPREP: begin
            a_ff <= a_red1;
            flip_ff <= flip_red;
            x_ff <= CORDIC_GAIN;
            y_ff <= '0;
            cnt_ff <= '0;
         end
         ST_CORDIC: begin
            if (a_ff >= 0) begin
               x_ff <= x_ff - y_shift;
               y_ff <= y_ff + x_shift;
               a_ff <= a_ff - atan_q30(cnt_ff[4:0]);
            end else begin
               x_ff <= x_ff + y_shift;
               y_ff <= y_ff - x_shift;
               a_ff <= a_ff + atan_q30(cnt_ff[4:0]);
            end
            cnt_ff <= (cnt_ff == 6'(CORDIC_RUN - 1)) ? 6'd0 : cnt_ff + 6'd1;
         end
         ST_XMUL: ;
         ST_YMUL: px_ff <= prod_sat;
         ST_EMIT: begin
            rsp_item_ff.pos_x <= px_ff;
            rsp_item_ff.pos_y <= prod_sat;
            if (z_ff > 34'sd2147483647)
               rsp_item_ff.pos_z <= 32'sh7FFFFFFF;
            else if (z_ff < -34'sd2147483648)
               rsp_item_ff.pos_z <= 32'sh80000000;
            else
               rsp_item_ff.pos_z <= z_ff[31:0];
            rsp_item_ff.coord_s <= u_ff;
            rsp_item_ff.coord_t <= v_ff;
            rsp_item_ff.last_vertex <= last_vtx;
            // Advance along the row, then to the next row.
            if ({1'b0, col_ff} == w_ff - 4'd1) begin
               col_ff <= '0;
               row_ff <= row_ff + 3'd1;
               u_ff <= us_ff;
               v_ff <= (v_next < {1'b0, ve_ff}) ? v_next[15:0] : ve_ff;
            end else begin
               col_ff <= col_ff + 3'd1;
               u_ff <= (u_next < {1'b0, ue_ff}) ? u_next[15:0] : ue_ff;
            end
         end
         default: ;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_item_ff;

endmodule
`default_nettype wire

[dv/tb_paraboloid_patch_dicer_core.sv]
// ---------------------------------------------------------------------------
// tb_paraboloid_patch_dicer_core
// Self-checking testbench of the paraboloid patch dicer. Patches are sent
// through the start/busy port under several register settings. A fixed-point
// vertex predictor in the testbench builds the expected vertex words, and
// every vertex word from the core is compared field by field in order.
// ---------------------------------------------------------------------------
`default_nettype none
module tb_paraboloid_patch_dicer_core import ppd_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   logic         clock = 1'b0;
   logic         reset;
   logic         start;
   logic         busy;
   req_item_type req_item;
   logic         rsp_valid;
   rsp_item_type rsp_item;
   logic         csr_we;
   logic [2:0]   csr_index;
   logic [31:0]  csr_wdata;

   paraboloid_patch_dicer_core u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Register copies held by the predictor.
   logic [30:0]        radius_reg;
   logic signed [31:0] zmin_reg;
   logic [30:0]        zmax_reg;
   logic [15:0]        sweep_reg;
   logic [3:0]         width_reg;
   logic [3:0]         height_reg;

   rsp_item_type vertex_queue[$];
   int           mismatch_count = 0;
   int           sender_idle_pct = 0;

   const longint arctan_q30[24] = '{
      843314857, 497837830, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
      65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};

   function automatic int grid_count(input logic [3:0] n);
      int res;
      res = n;
      if (res < 2) res = 2;
      if (res > MAX_GRID) res = MAX_GRID;
      return res;
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned n);
      longint unsigned res, bit_w;
      res = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > n) bit_w >>= 2;
      while (bit_w != 0) begin
         if (n >= res + bit_w) begin
            n -= res + bit_w;
            res = (res >> 1) + bit_w;
         end else begin
            res >>= 1;
         end
         bit_w >>= 2;
      end
      return res;
   endfunction

   function automatic logic signed [31:0] clip32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // Rotation-mode CORDIC in Q2.30 after folding theta into [-pi/2, pi/2].
   task automatic rotate_angle(input logic [31:0] theta, output longint c,
                               output longint s);
      longint a, x, y, nx;
      bit     flip;
      int     steps;
      a = longint'(theta) << 17;
      x = longint'(CORDIC_GAIN);
      y = 0;
      flip = 1'b0;
      steps = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
      if (a > longint'(Q30_PI)) a -= longint'(Q30_TWO_PI);
      if (a > longint'(Q30_HALF_PI)) begin
         a -= longint'(Q30_PI);
         flip = 1'b1;
      end else if (a < -longint'(Q30_HALF_PI)) begin
         a += longint'(Q30_PI);
         flip = 1'b1;
      end
      for (int i = 0; i < steps; i++) begin
         if (a >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            a -= arctan_q30[i];
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            a += arctan_q30[i];
         end
         x = nx;
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      c = x;
      s = y;
   endtask

   task automatic build_vertex(input logic [15:0] u, input logic [15:0] v,
                               output rsp_item_type w);
      longint          zmax, diff, z, r, c, s;
      longint unsigned ratio, rr;
      logic [31:0]     theta;
      zmax = (zmax_reg != 0) ? longint'(zmax_reg) : 1;
      diff = zmax - longint'(zmin_reg);
      z = longint'(zmin_reg) + ((diff * longint'(v)) >>> 16);
      theta = 32'((longint'(u) * longint'(sweep_reg)) >> 16);
      r = 0;
      if (z > 0) begin
         ratio = (longint'(unsigned'(z)) << 32) / longint'(unsigned'(zmax));
         rr = (longint'(unsigned'(longint'(radius_reg))) * int_sqrt(ratio)) >> 16;
         r = (rr > 64'd2147483647) ? 64'sd2147483647 : longint'(rr);
      end
      rotate_angle(theta, c, s);
      w.pos_x = clip32((r * c) >>> 30);
      w.pos_y = clip32((r * s) >>> 30);
      w.pos_z = clip32(z);
      w.coord_s = u;
      w.coord_t = v;
      w.last_vertex = 1'b0;
   endtask

   // Expands one patch into its row-major vertex words.
   task automatic dice_patch(input req_item_type p);
      logic [15:0]  us, ue, vs, ve, su, sv, u, v;
      logic [16:0]  t;
      int           gw, gh;
      rsp_item_type w;
      us = p.u_start;
      ue = (p.u_end < us) ? us : p.u_end;
      vs = p.v_start;
      ve = (p.v_end < vs) ? vs : p.v_end;
      gw = grid_count(width_reg);
      gh = grid_count(height_reg);
      su = 16'((ue - us) / (gw - 1));
      sv = 16'((ve - vs) / (gh - 1));
      v = vs;
      for (int j = 0; j < gh; j++) begin
         u = us;
         for (int i = 0; i < gw; i++) begin
            build_vertex(u, v, w);
            w.last_vertex = (i == gw - 1) && (j == gh - 1);
            vertex_queue = {vertex_queue, w};
            t = u + su;
            u = (t < ue) ? t[15:0] : ue;
         end
         t = v + sv;
         v = (t < ve) ? t[15:0] : ve;
      end
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid) begin
         if (vertex_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: unexpected vertex word %p", $realtime, rsp_item);
         end else begin
            want = vertex_queue.pop_front();
            if (rsp_item.pos_x !== want.pos_x || rsp_item.pos_y !== want.pos_y ||
                rsp_item.pos_z !== want.pos_z || rsp_item.coord_s !== want.coord_s ||
                rsp_item.coord_t !== want.coord_t ||
                rsp_item.last_vertex !== want.last_vertex) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: vertex mismatch expected %p actual %p",
                           $realtime, want, rsp_item);
            end
         end
      end
   end

   // Waits until the core is idle and nothing more is due.
   task automatic drain_core();
      start <= 1'b0;
      do @(posedge clock); while (vertex_queue.size() != 0 || busy);
      repeat (20) @(posedge clock);
   endtask

   task automatic send_patch(input req_item_type p);
      start <= 1'b1;
      req_item <= p;
      do @(posedge clock); while (busy);
      dice_patch(p);
      if ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   // Writes all six registers back to back, plus the unused indexes that
   // the core must ignore.
   task automatic program_regs(input logic [31:0] rad, input logic [31:0] zmin,
                               input logic [31:0] zmax, input logic [31:0] sweep,
                               input logic [31:0] gw, input logic [31:0] gh);
      logic [31:0] vals[8];
      drain_core();
      vals = '{rad, zmin, zmax, sweep, gw, gh, $urandom, $urandom};
      for (int i = 0; i < 8; i++) begin
         csr_we <= 1'b1;
         csr_index <= 3'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      radius_reg = rad[30:0];
      zmin_reg = zmin;
      zmax_reg = zmax[30:0];
      sweep_reg = sweep[15:0];
      width_reg = gw[3:0];
      height_reg = gh[3:0];
   endtask

   function automatic req_item_type make_patch(input logic [15:0] us,
                                               input logic [15:0] ue,
                                               input logic [15:0] vs,
                                               input logic [15:0] ve);
      req_item_type p;
      p.u_start = us;
      p.u_end = ue;
      p.v_start = vs;
      p.v_end = ve;
      return p;
   endfunction

   function automatic req_item_type random_patch();
      logic [15:0] a, b, c, d;
      a = 16'($urandom);
      b = 16'($urandom);
      c = 16'($urandom);
      d = 16'($urandom);
      // Mostly ordered ranges; the rest may put an end below its start.
      if ($urandom_range(9) < 8) begin
         if (b < a) {a, b} = {b, a};
         if (d < c) {c, d} = {d, c};
      end
      return make_patch(a, b, c, d);
   endfunction

   task automatic test_default_regs();
      // Registers at their reset values, full 8 by 8 grid.
      send_patch(make_patch(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF));
      send_patch(make_patch(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
   endtask

   task automatic test_grid_clamp();
      program_regs(32'h0001_0000, 32'h0, 32'h0001_0000, 32'd51472, 32'd0, 32'd1);
      send_patch(make_patch(16'h0000, 16'hFFFF, 16'h1000, 16'h8000));
      program_regs(32'h0001_0000, 32'h0, 32'h0001_0000, 32'd51472, 32'd15, 32'd9);
      send_patch(make_patch(16'h4000, 16'h2000, 16'h9000, 16'h1000));
   endtask

   task automatic test_extremes();
      // Negative heights, zero height limit and a large radius that saturates.
      program_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'd51472, 32'd2, 32'd3);
      send_patch(make_patch(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF));
      send_patch(make_patch(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA));
      program_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0, 32'd3, 32'd2);
      send_patch(make_patch(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF));
      program_regs(32'h0, 32'hFFFF_0000, 32'h1, 32'hFFFF, 32'd2, 32'd2);
      send_patch(make_patch(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF));
      program_regs(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd51472, 32'd4, 32'd2);
      send_patch(make_patch(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      send_patch(make_patch(16'h8000, 16'hC000, 16'h0001, 16'h0000));
      // Angles just around the quarter and half turns.
      program_regs(32'h0003_0000, 32'h0, 32'h0002_0000, 32'd51472, 32'd8, 32'd2);
      send_patch(make_patch(16'h3FF0, 16'h4010, 16'h8000, 16'hFFFF));
      send_patch(make_patch(16'h7FF0, 16'h8010, 16'h8000, 16'hFFFF));
   endtask

   task automatic test_random_phase(input int idle_pct, input int count);
      sender_idle_pct = idle_pct;
      program_regs($urandom, $urandom, $urandom_range(1, 32'h7FFF_FFFF),
                   $urandom_range(0, 51472), $urandom_range(2, 4),
                   $urandom_range(2, 4));
      for (int k = 0; k < count; k++) begin
         if (k == count / 2) begin
            // Hold the next patch back until the core has gone quiet.
            drain_core();
            program_regs($urandom_range(0, 32'h0010_0000),
                         $urandom_range(0, 32'h0001_0000) - 32'h8000,
                         $urandom_range(1, 32'h0004_0000),
                         $urandom_range(0, 51472), $urandom_range(2, 5),
                         $urandom_range(2, 3));
         end
         send_patch(random_patch());
      end
   endtask

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_item <= '0;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      radius_reg = 31'd65536;
      zmin_reg = 32'sd0;
      zmax_reg = 31'd65536;
      sweep_reg = 16'd51472;
      width_reg = 4'd8;
      height_reg = 4'd8;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_regs();
      test_grid_clamp();
      test_extremes();
      test_random_phase(35, 40);
      test_random_phase(70, 40);
      test_random_phase(0, 35);
      drain_core();
      repeat (200) @(posedge clock);
      if (mismatch_count == 0 && vertex_queue.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #200_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
`default_nettype wire

[paraboloid_patch_dicer_core.f]
src/ppd_pkg.sv
src/paraboloid_patch_dicer_core.sv
dv/tb_paraboloid_patch_dicer_core.sv
